### hdl/apt_pkg.sv
// apt_pkg: shared constants and types of the affine point transform core.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package apt_pkg;

    // Fixed-point format and geometry
    localparam int FRAC_BITS   = 16;
    localparam int DIMENSION   = 3;
    localparam int DIM_MAX     = 3;
    localparam int WORD_W      = 32;
    localparam int ENTRY_COUNT = 12;
    localparam int INDEX_W     = 4;
    localparam int TRANS_BASE  = 3 * DIM_MAX;   // first entry of the translation column
    localparam int DIAG_STEP   = DIM_MAX + 1;   // stride between diagonal entries

    // Datapath widths
    localparam int PROD_W  = 2 * WORD_W;
    localparam int SHIFT_W = PROD_W - FRAC_BITS;
    localparam int SUM_W   = SHIFT_W + 2;

    // Queue between front and back
    localparam int FIFO_PTR_W = 1;
    localparam int FIFO_DEPTH = 1 << FIFO_PTR_W;
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    // Operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_XFORM = 1'b1;

    localparam logic [WORD_W-1:0] FIX_ONE = WORD_W'(1) << FRAC_BITS;

    typedef logic [DIM_MAX-1:0][WORD_W-1:0] point_t;

    // Item as it travels through the queue
    typedef struct packed {
        logic               operation;
        logic [INDEX_W-1:0] entry_index;
        logic [WORD_W-1:0]  entry_value;
        point_t             point;
    } item_t;

endpackage

`default_nettype wire

### hdl/apt_item_if.sv
// apt_item_if: input channel of the affine point transform core.
// Depends on apt_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface apt_item_if;
    logic                               valid;
    logic                               ready;
    logic                               operation;
    logic [apt_pkg::INDEX_W-1:0]        entry_index;
    logic signed [apt_pkg::WORD_W-1:0]  entry_value;
    logic signed [apt_pkg::WORD_W-1:0]  point_x;
    logic signed [apt_pkg::WORD_W-1:0]  point_y;
    logic signed [apt_pkg::WORD_W-1:0]  point_z;

    modport source (
        output valid, operation, entry_index, entry_value, point_x, point_y, point_z,
        input  ready
    );
    modport sink (
        input  valid, operation, entry_index, entry_value, point_x, point_y, point_z,
        output ready
    );
endinterface

`default_nettype wire

### hdl/apt_result_if.sv
// apt_result_if: result channel of the affine point transform core.
// Depends on apt_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface apt_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [apt_pkg::WORD_W-1:0]  out_x;
    logic signed [apt_pkg::WORD_W-1:0]  out_y;
    logic signed [apt_pkg::WORD_W-1:0]  out_z;
    logic                               saturated;

    modport source (
        output valid, out_x, out_y, out_z, saturated,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z, saturated,
        output ready
    );
endinterface

`default_nettype wire

### hdl/affine_point_transform_core.sv
// affine_point_transform_core: top level, front, queue and back joined.
// Depends on apt_pkg, apt_item_if, apt_result_if, apt_front, apt_fifo, apt_back.
//
//   Channel   Direction   Transaction
//   item      in          load one matrix entry, or a point to transform
//   result    out         transformed point and saturation flag
//
// One item per cycle sustained while the result channel is not stalled; a
// transform passes through the two-entry queue and the multiply stage, and
// the sum stage feeds the result register. Loads take effect in queue order,
// so a transform always sees the loads before it. Reset (rst_n low) sets the
// matrix to the identity and empties the pipeline. A stalled result holds
// while the queue keeps taking items until it is full.
`timescale 1ns / 1ps
`default_nettype none

module affine_point_transform_core (
    input  wire logic     clk,
    input  wire logic     rst_n,
    apt_item_if.sink      item,
    apt_result_if.source  result
);

    apt_pkg::item_t push_data;
    apt_pkg::item_t head;
    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_empty;

    apt_front u_front (
        .item      (item),
        .q_full    (q_full),
        .push_data (push_data),
        .push      (push)
    );

    apt_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    apt_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_empty (q_empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

`default_nettype wire

### hdl/apt_front.sv
// apt_front: accepts input transactions, drops out-of-range loads and
// packs the rest for the queue. Depends on apt_pkg and apt_item_if.
`timescale 1ns / 1ps
`default_nettype none

module apt_front (
    apt_item_if.sink        item,
    input  wire logic       q_full,
    output apt_pkg::item_t  push_data,
    output logic            push
);

    logic keep;

    // A load beyond the matrix is taken and forgotten
    always_comb
    begin
        keep = (item.operation == apt_pkg::OP_XFORM)
            || (item.entry_index < apt_pkg::INDEX_W'(apt_pkg::ENTRY_COUNT));
    end

    assign item.ready = !q_full;
    assign push       = item.valid && !q_full && keep;

    // Pack the transaction
    always_comb
    begin
        push_data.operation   = item.operation;
        push_data.entry_index = item.entry_index;
        push_data.entry_value = item.entry_value;
        push_data.point[0]    = item.point_x;
        push_data.point[1]    = item.point_y;
        push_data.point[2]    = item.point_z;
    end

endmodule

`default_nettype wire

### hdl/apt_fifo.sv
// apt_fifo: short register queue between the front and the back.
// Depends on apt_pkg for the item type and depth.
`timescale 1ns / 1ps
`default_nettype none

module apt_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire apt_pkg::item_t  push_data,
    input  wire logic            pop,
    output apt_pkg::item_t       head,
    output logic                 full,
    output logic                 empty
);

    apt_pkg::item_t                   mem_reg [apt_pkg::FIFO_DEPTH];
    logic [apt_pkg::FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [apt_pkg::FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [apt_pkg::FIFO_CNT_W-1:0]   count_reg, count_next;

    assign full  = (count_reg == apt_pkg::FIFO_CNT_W'(apt_pkg::FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### hdl/apt_back.sv
// apt_back: holds the matrix, executes loads and transforms in queue order.
// Two stages: products, then sum and saturation into the output register.
// Depends on apt_pkg and apt_result_if.
`timescale 1ns / 1ps
`default_nettype none

module apt_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire apt_pkg::item_t  head,
    input  wire logic            q_empty,
    output logic                 pop,
    apt_result_if.source         result
);

    localparam int DIM = apt_pkg::DIMENSION;

    logic [apt_pkg::WORD_W-1:0]        matrix_reg [apt_pkg::ENTRY_COUNT];

    logic                              s1_valid_reg, s1_valid_next;
    logic signed [apt_pkg::PROD_W-1:0] prod_reg  [DIM][DIM];
    logic signed [apt_pkg::WORD_W-1:0] trans_reg [DIM];

    logic                              out_valid_reg, out_valid_next;
    logic signed [apt_pkg::WORD_W-1:0] coord_reg [apt_pkg::DIM_MAX];
    logic signed [apt_pkg::WORD_W-1:0] coord_next [apt_pkg::DIM_MAX];
    logic [apt_pkg::DIM_MAX-1:0]       clip_row;
    logic                              sat_reg;

    logic out_free;
    logic out_load;
    logic s1_free;
    logic is_load;
    logic take_xform;

    // Handshake between stages
    always_comb
    begin
        out_free   = !out_valid_reg || result.ready;
        out_load   = s1_valid_reg && out_free;
        s1_free    = !s1_valid_reg || out_free;
        is_load    = (head.operation == apt_pkg::OP_LOAD);
        pop        = !q_empty && (is_load || s1_free);
        take_xform = pop && !is_load;

        s1_valid_next = s1_valid_reg;
        if (take_xform)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Matrix store, identity after reset, one entry written per load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < apt_pkg::ENTRY_COUNT; i++)
            begin
                if ((i < apt_pkg::TRANS_BASE) && (i % apt_pkg::DIAG_STEP == 0))
                begin
                    matrix_reg[i] <= apt_pkg::FIX_ONE;
                end
                else
                begin
                    matrix_reg[i] <= '0;
                end
            end
        end
        else if (pop && is_load)
        begin
            matrix_reg[head.entry_index] <= head.entry_value;
        end
    end

    // Stage 1: one multiplier per entry of the 3x3 linear part, translation carried along
    for (genvar r = 0; r < DIM; r++)
    begin : g_prod_row
        for (genvar c = 0; c < DIM; c++)
        begin : g_prod_col
            logic signed [apt_pkg::WORD_W-1:0] m_val;
            logic signed [apt_pkg::WORD_W-1:0] p_val;
            assign m_val = matrix_reg[r + apt_pkg::DIM_MAX * c];
            assign p_val = head.point[c];
            always_ff @(posedge clk)
            begin
                if (take_xform)
                begin
                    prod_reg[r][c] <= m_val * p_val;
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (take_xform)
            begin
                trans_reg[r] <= matrix_reg[apt_pkg::TRANS_BASE + r];
            end
        end
    end

    // Stage 2: floor-shifted products plus translation, saturated once
    for (genvar r = 0; r < apt_pkg::DIM_MAX; r++)
    begin : g_sum_row
        if (r < DIM)
        begin : g_live
            logic signed [apt_pkg::SUM_W-1:0] acc;
            always_comb
            begin
                acc = apt_pkg::SUM_W'(trans_reg[r]);
                for (int c = 0; c < DIM; c++)
                begin
                    acc = acc + apt_pkg::SUM_W'(prod_reg[r][c] >>> apt_pkg::FRAC_BITS);
                end
                // Out of range when the sign bit and the bits above it are not all equal
                clip_row[r] = !((&acc[apt_pkg::SUM_W-1:apt_pkg::WORD_W-1])
                             || !(|acc[apt_pkg::SUM_W-1:apt_pkg::WORD_W-1]));
                if (clip_row[r])
                begin
                    coord_next[r] = acc[apt_pkg::SUM_W-1]
                        ? {1'b1, {(apt_pkg::WORD_W-1){1'b0}}}
                        : {1'b0, {(apt_pkg::WORD_W-1){1'b1}}};
                end
                else
                begin
                    coord_next[r] = acc[apt_pkg::WORD_W-1:0];
                end
            end
        end
        else
        begin : g_unused
            assign clip_row[r]   = 1'b0;
            assign coord_next[r] = '0;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            for (int r = 0; r < apt_pkg::DIM_MAX; r++)
            begin
                coord_reg[r] <= coord_next[r];
            end
            sat_reg <= |clip_row;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.out_x     = coord_reg[0];
    assign result.out_y     = coord_reg[1];
    assign result.out_z     = coord_reg[2];
    assign result.saturated = sat_reg;

endmodule

`default_nettype wire

### dv/apt_xform_check.sv
// apt_xform_check: watches both channels of the affine point transform core,
// keeps its own copy of the 3x4 matrix and compares every result point.
// Depends on apt_pkg, apt_item_if and apt_result_if.
`timescale 1ns / 1ps

module apt_xform_check (
    input  logic    clk,
    input  logic    rst_n,
    apt_item_if     item_mon,
    apt_result_if   result_mon,
    output int      fail_count,
    output int      pending
);

    localparam int W = apt_pkg::WORD_W;

    localparam logic signed [63:0] SUM_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SUM_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [W-1:0] out_x;
        logic signed [W-1:0] out_y;
        logic signed [W-1:0] out_z;
        logic                saturated;
    } point_result_t;

    // Shadow matrix, entry = row + 3 * column, column 3 is the translation
    logic signed [W-1:0] coeff [apt_pkg::ENTRY_COUNT];
    point_result_t       expected_points [$];

    task automatic load_identity();
        for (int i = 0; i < apt_pkg::ENTRY_COUNT; i++)
        begin
            coeff[i] = '0;
        end
        for (int r = 0; r < apt_pkg::DIM_MAX; r++)
        begin
            coeff[r * apt_pkg::DIAG_STEP] = apt_pkg::FIX_ONE;
        end
    endtask

    // Full-width sum of translation and floor-shifted products, clipped once
    function automatic point_result_t map_point(input logic signed [W-1:0] px,
                                                input logic signed [W-1:0] py,
                                                input logic signed [W-1:0] pz);
        logic signed [W-1:0]  coord [3];
        logic signed [W-1:0]  outc [3];
        logic signed [63:0]   acc;
        logic signed [63:0]   prod;
        point_result_t        res;
        coord[0] = px;
        coord[1] = py;
        coord[2] = pz;
        res.saturated = 1'b0;
        for (int r = 0; r < 3; r++)
        begin
            acc = 0;
            if (r < apt_pkg::DIMENSION)
            begin
                acc = coeff[r + apt_pkg::TRANS_BASE];
                for (int c = 0; c < 3 && c < apt_pkg::DIMENSION; c++)
                begin
                    prod = coeff[r + 3 * c];
                    prod = prod * coord[c];
                    acc  = acc + (prod >>> apt_pkg::FRAC_BITS);
                end
                if (acc > SUM_MAX)
                begin
                    acc = SUM_MAX;
                    res.saturated = 1'b1;
                end
                else if (acc < SUM_MIN)
                begin
                    acc = SUM_MIN;
                    res.saturated = 1'b1;
                end
            end
            outc[r] = acc[W-1:0];
        end
        res.out_x = outc[0];
        res.out_y = outc[1];
        res.out_z = outc[2];
        return res;
    endfunction

    // Only the first ten failures get a line of their own
    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%0t apt_xform_check: %s", $realtime, msg);
        end
    endtask

    // Result check first, so a point accepted on this edge is never popped early
    always @(posedge clk or negedge rst_n)
    begin
        point_result_t got;
        point_result_t want;
        if (!rst_n)
        begin
            load_identity();
            expected_points.delete();
            pending = 0;
        end
        else
        begin
            if (result_mon.valid && result_mon.ready)
            begin
                got.out_x     = result_mon.out_x;
                got.out_y     = result_mon.out_y;
                got.out_z     = result_mon.out_z;
                got.saturated = result_mon.saturated;
                if (expected_points.size() == 0)
                begin
                    note_failure($sformatf("unexpected result x=%0d y=%0d z=%0d sat=%0b",
                                           got.out_x, got.out_y, got.out_z, got.saturated));
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
                        got.out_z !== want.out_z || got.saturated !== want.saturated)
                    begin
                        note_failure($sformatf(
                            "mismatch exp x=%0d y=%0d z=%0d sat=%0b got x=%0d y=%0d z=%0d sat=%0b",
                            want.out_x, want.out_y, want.out_z, want.saturated,
                            got.out_x, got.out_y, got.out_z, got.saturated));
                    end
                end
            end
            if (item_mon.valid && item_mon.ready)
            begin
                if (item_mon.operation == apt_pkg::OP_LOAD)
                begin
                    // out-of-range index leaves the matrix untouched
                    if (item_mon.entry_index < apt_pkg::ENTRY_COUNT)
                    begin
                        coeff[item_mon.entry_index] = item_mon.entry_value;
                    end
                end
                else
                begin
                    expected_points.push_back(map_point(item_mon.point_x,
                                                        item_mon.point_y,
                                                        item_mon.point_z));
                end
            end
            pending = expected_points.size();
        end
    end

endmodule

### dv/tb_top.sv
// tb_top: stimulus and verdict for affine_point_transform_core.
// Depends on apt_pkg, the two channel interfaces, the core and apt_xform_check.
`timescale 1ns / 1ps

module tb_top;

    localparam int W            = apt_pkg::WORD_W;
    localparam int RANDOM_ITEMS = 1900;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 200000;

    localparam logic signed [W-1:0] FIX_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [W-1:0] FIX_MIN = 32'sh8000_0000;
    localparam logic signed [W-1:0] FIX_ONE = apt_pkg::FIX_ONE;
    localparam logic signed [W-1:0] FIX_HALF = FIX_ONE >>> 1;

    logic clk;
    logic rst_n;
    logic rx_ready;
    logic long_hold;
    bit   tx_burst;
    int   fail_count;
    int   pending;
    int   cycle_count;

    apt_item_if   item_ch ();
    apt_result_if result_ch ();

    assign result_ch.ready = rx_ready && !long_hold;

    affine_point_transform_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    apt_xform_check xform_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_mon   (item_ch),
        .result_mon (result_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Mix of extremes, full-range words and modest Q16.16 values
    function automatic logic signed [W-1:0] rand_fixed();
        case ($urandom_range(0, 9))
            0:       return FIX_MAX;
            1:       return FIX_MIN;
            2, 3:    return $urandom;
            default: return $signed($urandom) >>> $urandom_range(4, 20);
        endcase
    endfunction

    // One transaction on the item channel, after a random gap unless in a burst
    task automatic offer_item(input logic op, input logic [apt_pkg::INDEX_W-1:0] idx,
                              input logic signed [W-1:0] val,
                              input logic signed [W-1:0] px,
                              input logic signed [W-1:0] py,
                              input logic signed [W-1:0] pz);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 10);
        repeat (gap)
        begin
            @(negedge clk);
            item_ch.valid <= 1'b0;
        end
        @(negedge clk);
        item_ch.valid       <= 1'b1;
        item_ch.operation   <= op;
        item_ch.entry_index <= idx;
        item_ch.entry_value <= val;
        item_ch.point_x     <= px;
        item_ch.point_y     <= py;
        item_ch.point_z     <= pz;
        do
            @(posedge clk);
        while (!(item_ch.valid && item_ch.ready));
    endtask

    // Unused fields carry random bits so that they are seen to be ignored
    task automatic send_load(input logic [apt_pkg::INDEX_W-1:0] idx,
                             input logic signed [W-1:0] val);
        offer_item(apt_pkg::OP_LOAD, idx, val, $urandom, $urandom, $urandom);
    endtask

    task automatic send_point(input logic signed [W-1:0] px,
                              input logic signed [W-1:0] py,
                              input logic signed [W-1:0] pz);
        offer_item(apt_pkg::OP_XFORM, 4'($urandom), $urandom, px, py, pz);
    endtask

    // Main sequence: reset, directed loads and points, random traffic, verdict
    initial
    begin
        int pick;
        // known values on every item input from time zero
        rst_n               = 1'b0;
        item_ch.valid       = 1'b0;
        item_ch.operation   = apt_pkg::OP_LOAD;
        item_ch.entry_index = '0;
        item_ch.entry_value = '0;
        item_ch.point_x     = '0;
        item_ch.point_y     = '0;
        item_ch.point_z     = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // identity matrix straight out of reset
        send_point(FIX_MAX, FIX_MIN, 32'sh0001_8000);
        send_point(-32'sd1, 32'sd1, -FIX_ONE);
        // every entry, extremes included
        send_load(4'd0, FIX_MAX);
        send_load(4'd1, FIX_MIN);
        send_load(4'd2, -32'sd1);
        send_load(4'd3, FIX_ONE);
        send_load(4'd4, FIX_HALF);
        send_load(4'd5, -FIX_ONE);
        send_load(4'd6, 32'sd0);
        send_load(4'd7, 32'sd1);
        send_load(4'd8, -FIX_HALF);
        send_load(4'd9, FIX_MAX);
        send_load(4'd10, FIX_MIN);
        send_load(4'd11, 32'sd0);
        // clipping both ways, floor rounding of negative products
        send_point(FIX_MAX, FIX_MAX, FIX_MAX);
        send_point(FIX_MIN, FIX_MIN, FIX_MIN);
        send_point(-32'sd1, -32'sd1, -32'sd1);
        send_point(32'sd0, 32'sd0, 32'sd0);
        // indexes past the matrix are dropped
        send_load(4'd12, FIX_ONE);
        send_load(4'd13, -32'sd1);
        send_load(4'd15, FIX_MIN);
        send_point(FIX_ONE, -FIX_ONE, 32'sh0003_4000);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 150 == 0)
            begin
                tx_burst = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 20)
            begin
                send_load(4'($urandom_range(0, apt_pkg::ENTRY_COUNT - 1)), rand_fixed());
            end
            else if (pick < 24)
            begin
                send_load(4'($urandom_range(apt_pkg::ENTRY_COUNT, 15)), $urandom);
            end
            else
            begin
                send_point(rand_fixed(), rand_fixed(), rand_fixed());
            end
        end
        @(negedge clk);
        item_ch.valid <= 1'b0;

        do
            @(negedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("tb_top: PASS");
        end
        else
        begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // Result side: random stall per transaction, with stall-free stretches
    initial
    begin : result_sink
        int gap;
        int taken;
        bit rx_burst;
        rx_ready = 1'b0;
        taken = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (taken % 100 == 0)
            begin
                rx_burst = ($urandom_range(0, 3) == 0);
            end
            gap = rx_burst ? 0 : $urandom_range(0, 10);
            repeat (gap)
            begin
                @(negedge clk);
                rx_ready <= 1'b0;
            end
            @(negedge clk);
            rx_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(result_ch.valid && result_ch.ready));
            taken++;
        end
    end

    // Long back-pressure: queue fills and the item channel must stall
    initial
    begin : hold_off
        int held;
        long_hold = 1'b0;
        wait (rst_n === 1'b1);
        repeat (2)
        begin
            repeat ($urandom_range(300, 3000)) @(negedge clk);
            long_hold <= 1'b1;
            for (held = 0; held < 300; held++)
            begin
                @(negedge clk);
            end
            long_hold <= 1'b0;
        end
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

### files.f
hdl/apt_pkg.sv
hdl/apt_item_if.sv
hdl/apt_result_if.sv
hdl/apt_front.sv
hdl/apt_fifo.sv
hdl/apt_back.sv
hdl/affine_point_transform_core.sv
dv/apt_xform_check.sv
dv/tb_top.sv
